// ===== hdl/bgd_pkg.sv =====
// Shared types and constants for the button gesture detector.
package bgd_pkg;

    localparam int CFG_W = 16;
    localparam int ACT_W = 2;
    localparam int NOW_W = 32;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the write port.
    localparam logic [CFG_IDX_W-1:0] IDX_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_SHORT_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_GAP_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SINGLE_CNF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_DOUBLE_CNF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_HOLD       = 3'd5;

    // Gesture machine states.
    localparam logic [2:0] G_IDLE    = 3'd0;
    localparam logic [2:0] G_PRESS1  = 3'd1;
    localparam logic [2:0] G_WAIT2   = 3'd2;
    localparam logic [2:0] G_PRESS2  = 3'd3;
    localparam logic [2:0] G_WAITDBL = 3'd4;
    localparam logic [2:0] G_HOLD    = 3'd5;

    // Gesture codes.
    localparam logic [ACT_W-1:0] ACT_SINGLE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DOUBLE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HOLD    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_HOLDREL = 2'd3;

    // Timing thresholds in milliseconds.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_press_max_ms;
        logic [CFG_W-1:0] double_gap_max_ms;
        logic [CFG_W-1:0] single_confirm_ms;
        logic [CFG_W-1:0] double_confirm_ms;
        logic [CFG_W-1:0] hold_ms;
    } t_cfg;

    // Outcome of one sample: a gesture report or nothing.
    typedef struct packed {
        logic             valid;
        logic [ACT_W-1:0] action;
    } t_result;

endpackage

// ===== hdl/bgd_cfg_regs.sv =====
// Configuration register bank for the button gesture detector.
module bgd_cfg_regs
    import bgd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                IDX_DEBOUNCE:   n_cfg.debounce_ms        = i_cfg_data;
                IDX_SHORT_MAX:  n_cfg.short_press_max_ms = i_cfg_data;
                IDX_GAP_MAX:    n_cfg.double_gap_max_ms  = i_cfg_data;
                IDX_SINGLE_CNF: n_cfg.single_confirm_ms  = i_cfg_data;
                IDX_DOUBLE_CNF: n_cfg.double_confirm_ms  = i_cfg_data;
                IDX_HOLD:       n_cfg.hold_ms            = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms        <= 16'd20;
            r_cfg.short_press_max_ms <= 16'd500;
            r_cfg.double_gap_max_ms  <= 16'd400;
            r_cfg.single_confirm_ms  <= 16'd450;
            r_cfg.double_confirm_ms  <= 16'd200;
            r_cfg.hold_ms            <= 16'd800;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/bgd_gesture_core.sv =====
// Debounce filter and gesture state machine, one sample per enabled cycle.
module bgd_gesture_core
    import bgd_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_raw,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  t_cfg                  i_cfg,
    output t_result               o_result
);

    logic                  r_seeded;
    logic                  r_raw;
    logic [TIME_WIDTH-1:0] r_chg;
    logic                  r_stable;
    logic [2:0]            r_gs;
    logic [TIME_WIDTH-1:0] r_press;
    logic [TIME_WIDTH-1:0] r_rel;

    logic                  n_raw;
    logic [TIME_WIDTH-1:0] n_chg;
    logic                  n_stable;
    logic [2:0]            n_gs;
    logic [TIME_WIDTH-1:0] n_press;
    logic [TIME_WIDTH-1:0] n_rel;

    logic [TIME_WIDTH-1:0] w_deb;
    logic [TIME_WIDTH-1:0] w_short;
    logic [TIME_WIDTH-1:0] w_gap;
    logic [TIME_WIDTH-1:0] w_single;
    logic [TIME_WIDTH-1:0] w_double;
    logic [TIME_WIDTH-1:0] w_hold;

    logic [TIME_WIDTH-1:0] d_chg;
    logic [TIME_WIDTH-1:0] d_press_old;
    logic [TIME_WIDTH-1:0] d_rel_old;
    logic [TIME_WIDTH-1:0] d_press;
    logic [TIME_WIDTH-1:0] d_rel;
    logic                  w_done;
    t_result               w_res;

    assign w_deb    = TIME_WIDTH'(i_cfg.debounce_ms);
    assign w_short  = TIME_WIDTH'(i_cfg.short_press_max_ms);
    assign w_gap    = TIME_WIDTH'(i_cfg.double_gap_max_ms);
    assign w_single = TIME_WIDTH'(i_cfg.single_confirm_ms);
    assign w_double = TIME_WIDTH'(i_cfg.double_confirm_ms);
    assign w_hold   = TIME_WIDTH'(i_cfg.hold_ms);

    // Raw level tracking; the first sample always loads.
    always_comb begin
        n_raw = r_raw;
        n_chg = r_chg;
        if (!r_seeded || (i_raw != r_raw)) begin
            n_raw = i_raw;
            n_chg = i_now;
        end
    end

    assign d_chg       = i_now - n_chg;
    assign d_press_old = i_now - r_press;
    assign d_rel_old   = i_now - r_rel;
    assign d_press     = i_now - n_press;
    assign d_rel       = i_now - n_rel;

    always_comb begin
        n_stable     = r_stable;
        n_gs         = r_gs;
        n_press      = r_press;
        n_rel        = r_rel;
        w_done       = 1'b0;
        w_res.valid  = 1'b0;
        w_res.action = ACT_SINGLE;

        // Debounced edge handling.
        if ((n_raw != r_stable) && (d_chg >= w_deb)) begin
            n_stable = n_raw;
            if (n_raw) begin
                if ((r_gs == G_WAIT2) && (d_rel_old <= w_gap)) begin
                    n_press = i_now;
                    n_gs    = G_PRESS2;
                end else if ((r_gs != G_PRESS1) && (r_gs != G_PRESS2) &&
                             (r_gs != G_HOLD)) begin
                    n_press = i_now;
                    n_gs    = G_PRESS1;
                end
            end else begin
                if ((r_gs == G_PRESS1) || (r_gs == G_PRESS2)) begin
                    if (d_press_old <= w_short) begin
                        n_rel = i_now;
                        n_gs  = (r_gs == G_PRESS1) ? G_WAIT2 : G_WAITDBL;
                    end else begin
                        n_gs = G_IDLE;
                    end
                end else if (r_gs == G_HOLD) begin
                    n_gs         = G_IDLE;
                    w_done       = 1'b1;
                    w_res.valid  = 1'b1;
                    w_res.action = ACT_HOLDREL;
                end
            end
        end

        // Elapsed-time checks, skipped once a hold release was reported.
        if (!w_done) begin
            if (n_stable) begin
                if (((n_gs == G_PRESS1) || (n_gs == G_PRESS2)) && (d_press >= w_hold)) begin
                    n_gs         = G_HOLD;
                    w_res.valid  = 1'b1;
                    w_res.action = ACT_HOLD;
                end
            end else if ((n_gs == G_WAIT2) && (d_rel >= w_single)) begin
                n_gs         = G_IDLE;
                w_res.valid  = 1'b1;
                w_res.action = ACT_SINGLE;
            end else if ((n_gs == G_WAITDBL) && (d_rel >= w_double)) begin
                n_gs         = G_IDLE;
                w_res.valid  = 1'b1;
                w_res.action = ACT_DOUBLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_raw    <= 1'b0;
            r_chg    <= '0;
            r_stable <= 1'b0;
            r_gs     <= G_IDLE;
            r_press  <= '0;
            r_rel    <= '0;
        end else if (i_step) begin
            r_seeded <= 1'b1;
            r_raw    <= n_raw;
            r_chg    <= n_chg;
            r_stable <= n_stable;
            r_gs     <= n_gs;
            r_press  <= n_press;
            r_rel    <= n_rel;
        end
    end

    assign o_result = w_res;

endmodule

// ===== hdl/button_gesture_detector.sv =====
// Top level of the button gesture detector with stream ports and register bank.
//
// Usage: each request on the slave stream is one sample of the button: the
// raw pressed level and a free running millisecond timestamp. The block
// debounces the level and recognizes single press, double press, hold and
// hold release gestures. Each sample yields zero or one gesture request on the
// master stream; samples that cause no gesture produce nothing at the output.
// Thresholds are written through the plain register port (index 0 debounce,
// 1 short press max, 2 double gap max, 3 single confirm, 4 double confirm,
// 5 hold), only while the block is idle; the user is bound to this and the
// block itself does not enforce it. A gesture is presented on the master
// stream from the result register, behind the input register (one input
// register, one result register). Throughput is one sample per clock while
// the receiver does not stall, set by one pass of the gesture logic between them.
// Stalls: when the receiver holds m_axis_tready low, the result register keeps
// its request, one more sample waits in the input register, and s_axis_tready
// then drops until the result is taken. No request is lost or repeated.
// Reset (synchronous, active low) empties both registers, restores the
// register defaults and returns the debouncer and gesture machine to idle with
// no sample seen.
module button_gesture_detector
    import bgd_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,  // [0] raw_pressed, [32:1] now_ms, rest zero
    // Gesture stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [1:0] action, rest zero
    // Register write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg            w_cfg;
    t_result         w_res;
    logic            w_adv;
    logic            w_in_acc;

    logic            r_in_valid;
    logic            r_in_raw;
    logic [NOW_W-1:0] r_in_now;
    logic            r_out_valid;
    logic [ACT_W-1:0] r_out_action;

    bgd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // The held sample advances whenever the result register is free or
    // being emptied in this cycle.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    bgd_gesture_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_raw    (r_in_raw),
        .i_now    (TIME_WIDTH'(r_in_now)),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_raw <= s_axis_tdata[0];
            r_in_now <= s_axis_tdata[NOW_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_action <= w_res.action;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_action};

endmodule
